>>> hw/rtl/sha256_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared constants, types and round functions.
// ---------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic {
    REQ_ABSORB = 1'b0,
    REQ_FINISH = 1'b1
  } req_t;

  // command handed from the front part to the engine
  typedef struct packed {
    req_t       req;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PADB,
    ST_PADZ,
    ST_PADL,
    ST_CREAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } eng_state_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sha256_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 command queue
// Short register queue between the accepting front and the engine.
// ---------------------------------------------------------------------------
module sha256_fifo #(
  parameter int unsigned DEPTH = sha256_pkg::QueueDepth
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire sha256_pkg::cmd_t  wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output sha256_pkg::cmd_t       rd_data,
  output logic                   empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha256_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (rd_en && !empty && !(wr_en && !full)) |=> !full)
    else $error("queue full after pop");
  assert property (@(posedge clk) disable iff (rst)
    (wr_en && !full && !(rd_en && !empty)) |=> !empty)
    else $error("queue empty after push");

endmodule
`default_nettype wire

>>> hw/rtl/sha256_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 engine
// Block store, padding sequencer, one round per cycle with a rolling
// 16-word schedule window, and a one-entry digest output register.
// ---------------------------------------------------------------------------
module sha256_engine (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  input  wire sha256_pkg::cmd_t cmd,
  output logic              cmd_take,
  output logic              empty,
  input  wire logic         pop,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_word
);
  sha256_pkg::eng_state_t state, state_next;

  logic [31:0] chain [8];
  logic [31:0] v     [8];
  logic [31:0] w     [16];   // block store as words, then schedule window
  logic [5:0]  fill;
  logic [60:0] total;
  logic [5:0]  rnd;
  logic        finishing;   // compression belongs to padding
  logic        second;      // length still goes in a new block
  logic [2:0]  emit_idx;
  logic        out_valid;

  logic [63:0] bits;
  logic [31:0] t1, t2, w_new, w_cur;
  logic        store_byte;
  logic [7:0]  store_val;

  assign bits  = {total, 3'b000};
  assign w_cur = w[0];
  assign w_new = sha256_pkg::ssig1(w[14]) + w[9] + sha256_pkg::ssig0(w[1]) + w[0];
  assign t1 = v[7] + sha256_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
              + sha256_pkg::K_ROUND[rnd] + w_cur;
  assign t2 = sha256_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign empty       = !out_valid;
  assign digest_word = chain[emit_idx];
  assign word_index  = emit_idx;
  assign last_word   = (emit_idx == 3'd7);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.req == sha256_pkg::REQ_FINISH) ? sha256_pkg::ST_PADB
                                                           : sha256_pkg::ST_LOAD;
        end
      end
      sha256_pkg::ST_LOAD:
        state_next = (fill == 6'd63) ? sha256_pkg::ST_CREAD : sha256_pkg::ST_IDLE;
      sha256_pkg::ST_PADB:
        state_next = (fill == 6'd63) ? sha256_pkg::ST_CREAD
                   : (fill >= sha256_pkg::LEN_POS) ? sha256_pkg::ST_PADZ
                   : (fill == sha256_pkg::LEN_POS - 6'd1) ? sha256_pkg::ST_PADL
                   : sha256_pkg::ST_PADZ;
      sha256_pkg::ST_PADZ: begin
        if (second) begin
          state_next = (fill == 6'd63) ? sha256_pkg::ST_CREAD : sha256_pkg::ST_PADZ;
        end else begin
          state_next = (fill == sha256_pkg::LEN_POS - 6'd1) ? sha256_pkg::ST_PADL
                                                            : sha256_pkg::ST_PADZ;
        end
      end
      sha256_pkg::ST_PADL:
        state_next = (fill == 6'd63) ? sha256_pkg::ST_CREAD : sha256_pkg::ST_PADL;
      sha256_pkg::ST_CREAD: state_next = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND:
        state_next = (rnd == 6'd63) ? sha256_pkg::ST_ADD : sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ADD: begin
        if (!finishing)   state_next = sha256_pkg::ST_IDLE;
        else if (second)  state_next = sha256_pkg::ST_PADZ;
        else              state_next = sha256_pkg::ST_EMIT;
      end
      sha256_pkg::ST_EMIT:
        state_next = (pop && out_valid && emit_idx == 3'd7) ? sha256_pkg::ST_IDLE
                                                            : sha256_pkg::ST_EMIT;
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_take   = 1'b0;
    store_byte = 1'b0;
    store_val  = cmd.data;
    unique case (state)
      sha256_pkg::ST_IDLE: cmd_take = cmd_valid;
      sha256_pkg::ST_LOAD: store_byte = 1'b1;
      sha256_pkg::ST_PADB: begin
        store_byte = 1'b1;
        store_val  = sha256_pkg::PAD_BYTE;
      end
      sha256_pkg::ST_PADZ: begin
        store_byte = 1'b1;
        store_val  = 8'h00;
      end
      sha256_pkg::ST_PADL: begin
        store_byte = 1'b1;
        store_val  = bits[8'(7 - (fill - sha256_pkg::LEN_POS)) * 8 +: 8];
      end
      default: ;
    endcase
  end

  logic [7:0] pend_byte;

  always_ff @(posedge clk) begin
    if (state == sha256_pkg::ST_IDLE && cmd_valid) begin
      pend_byte <= cmd.data;
    end
    if (store_byte) begin
      for (int i = 0; i < 4; i++) begin
        if (fill[1:0] == 2'(i)) begin
          w[fill[5:2]][31-8*i -: 8] <= (state == sha256_pkg::ST_LOAD) ? pend_byte
                                                                      : store_val;
        end
      end
    end
    if (state == sha256_pkg::ST_CREAD) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end
    if (state == sha256_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha256_pkg::ST_IDLE;
      fill      <= '0;
      total     <= '0;
      rnd       <= '0;
      finishing <= 1'b0;
      second    <= 1'b0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::H_INIT[i];
    end else begin
      state <= state_next;
      if (state == sha256_pkg::ST_IDLE && cmd_valid) begin
        finishing <= (cmd.req == sha256_pkg::REQ_FINISH);
      end
      if (store_byte) fill <= fill + 6'd1;
      if (state == sha256_pkg::ST_LOAD) total <= total + 61'd1;
      if (state == sha256_pkg::ST_PADB) begin
        second <= (fill >= sha256_pkg::LEN_POS);
      end
      if (state == sha256_pkg::ST_PADZ && !second
          && fill == sha256_pkg::LEN_POS - 6'd1) begin
        second <= 1'b0;
      end
      if (state == sha256_pkg::ST_ROUND) rnd <= rnd + 6'd1;
      if (state == sha256_pkg::ST_ADD) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
        // after the overflow block, pad zeros then length in a fresh block
        if (second) second <= 1'b0;
        if (finishing && !second) begin
          out_valid <= 1'b1;
          emit_idx  <= '0;
        end
      end
      if (state == sha256_pkg::ST_EMIT && pop && out_valid) begin
        emit_idx <= emit_idx + 3'd1;
        if (emit_idx == 3'd7) begin
          out_valid <= 1'b0;
          fill      <= '0;
          total     <= '0;
          finishing <= 1'b0;
          for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::H_INIT[i];
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == sha256_pkg::ST_EMIT)
    else $error("digest shown outside emit");
  assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> state == sha256_pkg::ST_IDLE && !out_valid)
    else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == sha256_pkg::ST_ROUND && rnd == 6'd63) |=> state == sha256_pkg::ST_ADD)
    else $error("round count slipped");
  assert property (@(posedge clk) disable iff (rst)
    (state == sha256_pkg::ST_PADL) |-> fill >= sha256_pkg::LEN_POS)
    else $error("length written too early");

endmodule
`default_nettype wire

>>> hw/rtl/sha256_stream_hasher_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-stream SHA-256 with queue-style input and digest output.
//
// channel   direction  handshake        payload
// input     in         push / full      req_type, data_byte
// result    out        pop / empty      digest_word, word_index, last_word
//
// An absorb byte passes engine states IDLE and LOAD; the 64th byte of a block
// adds CREAD, the round loop and ADD (one round per cycle, one shared unit).
// Finish takes the padding bytes at one per cycle plus one or two blocks.
// The input queue takes items until full while the engine compresses or emits.
// rst clears all control state and loads the initial hash values.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_top #(
  parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        req_type,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);
  sha256_pkg::cmd_t in_cmd, q_cmd;
  logic q_empty, q_take;

  assign in_cmd.req  = sha256_pkg::req_t'(req_type);
  assign in_cmd.data = data_byte;

  sha256_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (in_cmd),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  sha256_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (!q_empty),
    .cmd         (q_cmd),
    .cmd_take    (q_take),
    .empty       (empty),
    .pop         (pop),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule
`default_nettype wire
